// ----- hw/rtl/sfr_crc_pkg.sv -----
// Shared types, constants and the byte-wide CRC-32 update for the sync frame receiver.
// Used by sync_frame_receiver_crc32 and sfr_crc_out_skid; depends on nothing else.
`default_nettype none

package sfr_crc_pkg;

  localparam int PAYLOAD_LIMIT = 1024;

  localparam logic [7:0] SYNC_FIRST_RESET  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'h55;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [0:0] REG_SYNC_FIRST  = 1'd0;
  localparam logic [0:0] REG_SYNC_SECOND = 1'd1;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_CRCERR  = 2'd2;
  localparam logic [1:0] KIND_LENREJ  = 2'd3;

  localparam int OUT_DATA_W = 128;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic [7:0]  command;
    logic [15:0] sequence_res;
    logic [15:0] payload_length;
    logic [31:0] frames_good;
    logic [31:0] frames_bad;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sfr_crc_out_skid.sv -----
// Two-entry output register with skid stage for result beats.
// Depends on sfr_crc_pkg for the result type.
`default_nettype none

module sfr_crc_out_skid (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  sfr_crc_pkg::result_t  push_data,
  output logic                  ready,
  output logic                  valid,
  input  wire                   take,
  output sfr_crc_pkg::result_t  data
);

  logic                 main_valid;
  logic                 skid_valid;
  sfr_crc_pkg::result_t skid_data;

  assign ready = !skid_valid;
  assign valid = main_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (main_valid && take) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else if (!push) begin
          main_valid <= 1'b0;
        end
      end else if (push) begin
        if (!main_valid) begin
          main_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (main_valid && take) begin
      if (skid_valid) begin
        data <= skid_data;
      end else if (push) begin
        data <= push_data;
      end
    end else if (push) begin
      if (!main_valid) begin
        data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sync_frame_receiver_crc32.sv -----
// Top level of the sync frame receiver: sync hunt, header parse, cut-through payload, CRC-32 check.
// Depends on sfr_crc_pkg and sfr_crc_out_skid.
`default_nettype none

// The receiver takes one byte per beat and can accept a new byte in every cycle while the
// output side keeps up; each byte is fully processed in the cycle it is accepted, and its
// result, if any, is registered in the output register. The combinational byte-wide CRC-32
// update sets the rate. A two-entry output register lets one result wait while the next
// byte is taken; the input stalls only when both entries are full. Frames start with the
// programmable two-byte sync pattern, followed by command, little-endian length and
// sequence, the payload and a little-endian CRC-32 trailer over header and payload.
module sync_frame_receiver_crc32 (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [7:0]  cfg_data,
  input  wire         s_tvalid,
  output logic        s_tready,
  // Fields from bit 0 up: rx_byte[7:0].
  input  wire  [7:0]  s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // Fields from bit 0 up: payload_byte[7:0], payload_index[17:8], command[25:18],
  // sequence_res[41:26], payload_length[57:42], frames_good[89:58], frames_bad[121:90].
  output logic [sfr_crc_pkg::OUT_DATA_W-1:0] m_tdata,
  // Fields from bit 0 up: kind[1:0].
  output logic [1:0]  m_tuser
);

  localparam logic [2:0] PH_HUNT0 = 3'd0;
  localparam logic [2:0] PH_HUNT1 = 3'd1;
  localparam logic [2:0] PH_HEAD  = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_TRAIL = 3'd4;

  localparam logic [16:0] LIMIT = 17'(sfr_crc_pkg::PAYLOAD_LIMIT);

  logic [7:0]  sync_first;
  logic [7:0]  sync_second;

  logic [2:0]  phase, phase_next;
  logic [15:0] remaining, remaining_next;
  logic [2:0]  header_pos, header_pos_next;
  logic [7:0]  cur_command, cur_command_next;
  logic [15:0] cur_length, cur_length_next;
  logic [15:0] cur_sequence, cur_sequence_next;
  logic [9:0]  data_count, data_count_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] trailer_crc, trailer_crc_next;
  logic [31:0] good_count, good_count_next;
  logic [31:0] bad_count, bad_count_next;

  logic        accept;
  logic        res_push;
  logic        res_ready;
  logic        has_result;
  logic [1:0]  res_kind;
  logic [7:0]  res_byte;
  logic [9:0]  res_index;
  logic [7:0]  b;
  logic [31:0] crc_upd;
  logic [15:0] rem_dec;

  sfr_crc_pkg::result_t res_data;
  sfr_crc_pkg::result_t out_data;

  assign b        = s_tdata;
  assign s_tready = res_ready;
  assign accept   = s_tvalid && s_tready;
  assign res_push = accept && has_result;
  assign crc_upd  = sfr_crc_pkg::crc_byte(running_crc, b);
  assign rem_dec  = remaining - 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= sfr_crc_pkg::SYNC_FIRST_RESET;
      sync_second <= sfr_crc_pkg::SYNC_SECOND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfr_crc_pkg::REG_SYNC_FIRST:  sync_first  <= cfg_data;
        sfr_crc_pkg::REG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next        = phase;
    remaining_next    = remaining;
    header_pos_next   = header_pos;
    cur_command_next  = cur_command;
    cur_length_next   = cur_length;
    cur_sequence_next = cur_sequence;
    data_count_next   = data_count;
    running_crc_next  = running_crc;
    trailer_crc_next  = trailer_crc;
    good_count_next   = good_count;
    bad_count_next    = bad_count;
    has_result        = 1'b0;
    res_kind          = sfr_crc_pkg::KIND_PAYLOAD;
    res_byte          = 8'd0;
    res_index         = 10'd0;

    unique case (phase)
      PH_HUNT0: begin
        if (b == sync_first) begin
          phase_next = PH_HUNT1;
        end
      end
      PH_HUNT1: begin
        if (b == sync_second) begin
          phase_next       = PH_HEAD;
          header_pos_next  = 3'd0;
          running_crc_next = sfr_crc_pkg::CRC_INIT;
          data_count_next  = 10'd0;
          trailer_crc_next = 32'd0;
        end else if (b != sync_first) begin
          phase_next = PH_HUNT0;
        end
      end
      PH_HEAD: begin
        running_crc_next = crc_upd;
        case (header_pos)
          3'd0:    cur_command_next  = b;
          3'd1:    cur_length_next   = {cur_length[15:8], b};
          3'd2:    cur_length_next   = {b, cur_length[7:0]};
          3'd3:    cur_sequence_next = {cur_sequence[15:8], b};
          default: cur_sequence_next = {b, cur_sequence[7:0]};
        endcase
        header_pos_next = header_pos + 3'd1;
        if (header_pos == 3'd4) begin
          header_pos_next = 3'd0;
          data_count_next = 10'd0;
          trailer_crc_next = 32'd0;
          if ({1'b0, cur_length} > LIMIT) begin
            bad_count_next   = bad_count + 32'd1;
            has_result       = 1'b1;
            res_kind         = sfr_crc_pkg::KIND_LENREJ;
            phase_next       = PH_HUNT0;
            remaining_next   = 16'd0;
            running_crc_next = sfr_crc_pkg::CRC_INIT;
          end else if (cur_length == 16'd0) begin
            phase_next     = PH_TRAIL;
            remaining_next = 16'd4;
          end else begin
            phase_next     = PH_DATA;
            remaining_next = cur_length;
          end
        end
      end
      PH_DATA: begin
        running_crc_next = crc_upd;
        data_count_next  = data_count + 10'd1;
        remaining_next   = rem_dec;
        has_result       = 1'b1;
        res_kind         = sfr_crc_pkg::KIND_PAYLOAD;
        res_byte         = b;
        res_index        = data_count;
        if (rem_dec == 16'd0) begin
          phase_next     = PH_TRAIL;
          remaining_next = 16'd4;
        end
      end
      PH_TRAIL: begin
        trailer_crc_next = {b, trailer_crc[31:8]};
        remaining_next   = rem_dec;
        if (rem_dec == 16'd0) begin
          has_result = 1'b1;
          if (~running_crc == trailer_crc_next) begin
            good_count_next = good_count + 32'd1;
            res_kind        = sfr_crc_pkg::KIND_GOOD;
          end else begin
            bad_count_next = bad_count + 32'd1;
            res_kind       = sfr_crc_pkg::KIND_CRCERR;
          end
          phase_next       = PH_HUNT0;
          header_pos_next  = 3'd0;
          data_count_next  = 10'd0;
          running_crc_next = sfr_crc_pkg::CRC_INIT;
          trailer_crc_next = 32'd0;
        end
      end
      default: begin
        phase_next       = PH_HUNT0;
        remaining_next   = 16'd0;
        header_pos_next  = 3'd0;
        data_count_next  = 10'd0;
        running_crc_next = sfr_crc_pkg::CRC_INIT;
        trailer_crc_next = 32'd0;
      end
    endcase
  end

  always_comb begin
    res_data.kind           = res_kind;
    res_data.payload_byte   = res_byte;
    res_data.payload_index  = res_index;
    res_data.command        = cur_command_next;
    res_data.sequence_res   = cur_sequence_next;
    res_data.payload_length = cur_length_next;
    res_data.frames_good    = good_count_next;
    res_data.frames_bad     = bad_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT0;
      remaining    <= 16'd0;
      header_pos   <= 3'd0;
      cur_command  <= 8'd0;
      cur_length   <= 16'd0;
      cur_sequence <= 16'd0;
      data_count   <= 10'd0;
      running_crc  <= sfr_crc_pkg::CRC_INIT;
      trailer_crc  <= 32'd0;
      good_count   <= 32'd0;
      bad_count    <= 32'd0;
    end else if (accept) begin
      phase        <= phase_next;
      remaining    <= remaining_next;
      header_pos   <= header_pos_next;
      cur_command  <= cur_command_next;
      cur_length   <= cur_length_next;
      cur_sequence <= cur_sequence_next;
      data_count   <= data_count_next;
      running_crc  <= running_crc_next;
      trailer_crc  <= trailer_crc_next;
      good_count   <= good_count_next;
      bad_count    <= bad_count_next;
    end
  end

  sfr_crc_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .ready     (res_ready),
    .valid     (m_tvalid),
    .take      (m_tready),
    .data      (out_data)
  );

  assign m_tuser = out_data.kind;
  assign m_tdata = {6'd0, out_data.frames_bad, out_data.frames_good, out_data.payload_length,
                    out_data.sequence_res, out_data.command, out_data.payload_index,
                    out_data.payload_byte};

  // A byte accepted in the payload phase always produces a payload beat.
  assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_DATA) |-> (res_push && res_data.kind == sfr_crc_pkg::KIND_PAYLOAD))
    else $error("payload byte did not produce a payload beat");

  // The trailer countdown stays between one and four.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TRAIL) |-> (remaining != 16'd0 && remaining <= 16'd4))
    else $error("trailer countdown out of range");

  // A good frame result advances the good counter by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    (res_push && res_data.kind == sfr_crc_pkg::KIND_GOOD) |=>
      (good_count == $past(good_count) + 32'd1 && bad_count == $past(bad_count)))
    else $error("good counter did not advance with a good frame");

  // The payload phase is only entered with a nonzero count of bytes left.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (remaining != 16'd0))
    else $error("payload phase with no bytes left");

endmodule

`default_nettype wire
